[rtl/qas_pkg.sv]
// Package for the quoted argument splitter: character codes, parser flag
// bundle and the escape-letter mapping. No dependencies.
package qas_pkg;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_T     = 8'h74;

	// Parser flags carried from word to word
	typedef struct packed {
		logic inside_arg;
		logic in_quoted_arg;
		logic mid_quote;
		logic skip_next;
		logic token_open;
		logic escape_pending;
	} parse_state_t;

	localparam parse_state_t STATE_RESET = '0;

	// Second byte of an unescape pair -> output byte
	function automatic logic [7:0] map_escape(input logic [7:0] c);
		logic [7:0] r;
		case (c)
			CH_B:    r = 8'd8;
			CH_F:    r = 8'd12;
			CH_N:    r = 8'd10;
			CH_R:    r = 8'd13;
			CH_T:    r = 8'd9;
			default: r = c;
		endcase
		return r;
	endfunction

endpackage

[rtl/quoted_argument_splitter.sv]
// Quoted argument splitter: splits a zero-terminated command line into
// arguments and unescapes their content. Depends on qas_pkg.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------
//  in      | input     | in_valid / in_ready  | in_byte
//  out     | output    | out_valid / out_ready| out_byte, byte_valid, token_end, list_end
//
// One word per cycle while the output is not stalled: an input register
// feeds the flag update and result logic, which loads the output register
// in the same cycle. A result word passes the input register and then the
// output register, where it stays until out_ready takes it.
// arst_n clears all flags and both valid bits; the next word starts a new line.
// A stalled output register holds the input register; input is taken again
// as soon as the output word is taken or the slot is empty.
// Words that produce no result (gaps, opening quotes, dropped bytes, a
// waiting backslash) pass through without a result word.
module quoted_argument_splitter (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       token_end,
	output logic       list_end
);

	logic                  valid_s1;
	logic [7:0]            byte_s1;
	qas_pkg::parse_state_t state_q;
	qas_pkg::parse_state_t state_d;
	logic                  out_free;
	logic                  advance;
	logic                  res_has;
	logic [7:0]            res_byte;
	logic                  res_bvalid;
	logic                  res_tend;
	logic                  res_lend;
	logic                  content;
	logic                  end_tok;

	// Pipeline flow control
	assign out_free = !out_valid || out_ready;
	assign advance  = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	// Flag update and result for the word in the input register
	always_comb begin
		state_d    = state_q;
		content    = 1'b0;
		end_tok    = 1'b0;
		res_has    = 1'b0;
		res_byte   = 8'd0;
		res_bvalid = 1'b0;
		res_tend   = 1'b0;
		res_lend   = 1'b0;
		if (byte_s1 == qas_pkg::CH_NUL) begin
			// terminator ends the line whatever is pending
			state_d  = qas_pkg::STATE_RESET;
			res_has  = 1'b1;
			res_tend = state_q.token_open;
			res_lend = 1'b1;
		end else begin
			if (state_q.skip_next) begin
				state_d.skip_next = 1'b0;
				content = state_q.token_open;
			end else if (state_q.inside_arg) begin
				if (byte_s1 == qas_pkg::CH_BSL) begin
					state_d.skip_next = 1'b1;
					content = state_q.token_open;
				end else if (byte_s1 == qas_pkg::CH_QUOTE) begin
					if (state_q.in_quoted_arg) begin
						state_d.in_quoted_arg = 1'b0;
						end_tok = state_q.token_open;
					end else begin
						state_d.mid_quote = !state_q.mid_quote;
						content = state_q.token_open;
					end
				end else if (byte_s1 == qas_pkg::CH_SPACE) begin
					if (state_q.in_quoted_arg || state_q.mid_quote) begin
						content = state_q.token_open;
					end else begin
						state_d.inside_arg = 1'b0;
						end_tok = state_q.token_open;
					end
				end else begin
					content = state_q.token_open;
				end
			end else begin
				// between arguments
				if (byte_s1 == qas_pkg::CH_QUOTE) begin
					state_d.inside_arg     = 1'b1;
					state_d.in_quoted_arg  = 1'b1;
					state_d.token_open     = 1'b1;
					state_d.escape_pending = 1'b0;
				end else if (byte_s1 != qas_pkg::CH_SPACE) begin
					state_d.inside_arg     = 1'b1;
					state_d.token_open     = 1'b1;
					state_d.escape_pending = 1'b0;
					content                = 1'b1;
				end
			end

			// unescape and result selection
			if (end_tok) begin
				state_d.token_open     = 1'b0;
				state_d.escape_pending = 1'b0;
				res_has  = 1'b1;
				res_tend = 1'b1;
			end else if (content) begin
				if (state_d.escape_pending) begin
					state_d.escape_pending = 1'b0;
					res_has    = 1'b1;
					res_bvalid = 1'b1;
					res_byte   = qas_pkg::map_escape(byte_s1);
				end else if (byte_s1 == qas_pkg::CH_BSL) begin
					state_d.escape_pending = 1'b1;
				end else begin
					res_has    = 1'b1;
					res_bvalid = 1'b1;
					res_byte   = byte_s1;
				end
			end
		end
	end

	// Flags and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= qas_pkg::STATE_RESET;
			out_valid <= 1'b0;
		end else if (advance) begin
			state_q   <= state_d;
			out_valid <= res_has;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_has) begin
			out_byte   <= res_byte;
			byte_valid <= res_bvalid;
			token_end  <= res_tend;
			list_end   <= res_lend;
		end
	end

	// Checks
	a_excl_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(byte_valid && (token_end || list_end)))
		else $error("content byte and end mark in one word");

	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !byte_valid) |-> (out_byte == 8'd0))
		else $error("end word carries a nonzero byte");

	a_term_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && byte_s1 == qas_pkg::CH_NUL) |=> (state_q == qas_pkg::STATE_RESET))
		else $error("flags not cleared after terminator");

	a_term_word: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && byte_s1 == qas_pkg::CH_NUL) |=> (out_valid && list_end))
		else $error("terminator gave no list end");

	a_escape_open: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.escape_pending |-> state_q.token_open)
		else $error("pending escape outside an open argument");

endmodule
